// File: src/wpc_pkg.sv
package wpc_pkg;

    // Number of CORDIC micro-rotations, one register stage each (8 to 32).
    localparam int CORDIC_STAGES = 20;

    // Operand and result width, Q15.8.
    localparam int OPW = 24;
    // CORDIC vector width: 32 fraction bits plus headroom for the CORDIC gain.
    localparam int DW = 52;
    // Residual angle width: binary angle, 2^32 per turn, plus sign and headroom.
    localparam int ZW = 34;

    typedef logic [1:0]             t_mode;
    typedef logic signed [OPW-1:0]  t_operand;

    localparam t_mode MODE_EAST  = 2'd0;
    localparam t_mode MODE_NORTH = 2'd1;
    localparam t_mode MODE_SPEED = 2'd2;
    localparam t_mode MODE_DIR   = 2'd3;

    // Inverse CORDIC gain, Q0.32.
    localparam logic signed [32:0] KINV = 33'sd2608131496;

    // Degrees-to-binary-angle conversion. 92160 = 2048 * 45, so the angle is
    // floor((d * 2^21 + 22) / 45). The operand is offset by a multiple of 45
    // to make it non-negative before the reciprocal multiply.
    localparam int              DEG_DIV      = 45;
    localparam int              DIVIDEND_W   = 25;
    localparam int              QUOT_W       = 19;
    localparam int              RECIP_W      = 26;
    localparam int              RECIP_SHIFT  = 31;
    localparam int              OFFSET_QUOT  = 186414;
    localparam logic [DIVIDEND_W-1:0] DEG_OFFSET = DIVIDEND_W'(OFFSET_QUOT * DEG_DIV);
    localparam logic [RECIP_W-1:0]    RECIP45    =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEG_DIV) - 64'd1) / 64'(DEG_DIV));
    localparam logic [31:0]     Z_OFFSET     = 32'(64'(OFFSET_QUOT) << 21);

    localparam int DR_DEPTH = 45;
    localparam int DR_W     = 21;
    typedef logic [DR_DEPTH-1:0][DR_W-1:0] t_dr_tab;

    function automatic t_dr_tab build_dr_tab();
        t_dr_tab tab;
        tab = '0;
        for (int i = 0; i < DR_DEPTH; i++) begin
            tab[i] = DR_W'((64'(i) * 64'd2097152 + 64'd22) / 64'(DEG_DIV));
        end
        return tab;
    endfunction

    // Fractional part of the angle for each remainder of the degree value by 45.
    localparam t_dr_tab DR_TAB = build_dr_tab();

    // Arctangent of 2^-i as a binary angle.
    function automatic logic signed [ZW-1:0] atan_angle(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return $signed({{(ZW-32){1'b0}}, v});
    endfunction

    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'd1 << 30);
    localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'd1 << 31);

    // Degrees per turn in Q15.8, and the result limits.
    localparam logic signed [17:0]     DEG_FULL  = 18'sd92160;
    localparam logic signed [OPW-1:0]  RES_MAX   = 24'sd8388607;
    localparam logic signed [OPW-1:0]  RES_MIN   = -24'sd8388608;
    localparam logic signed [OPW-1:0]  DIR_ZERO  = -24'sd46080;

    // Slice of the final CORDIC x that feeds the speed gain correction.
    localparam int SPD_LSB = 18;
    localparam int SPD_W   = 31;

endpackage

// File: src/wind_polar_cartesian_convert.sv
// Throughput: one item per clock cycle; busy is never asserted, since the fully
// unrolled CORDIC pipeline advances every cycle and the receiver cannot stall.
// Reset (synchronous, active low) clears the mode register to east component and
// empties the pipeline; items in flight are dropped and no strobe follows.
module wind_polar_cartesian_convert (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  wpc_pkg::t_mode     i_cfg_wdata,
    input  wpc_pkg::t_operand  i_operand_a,
    input  wpc_pkg::t_operand  i_operand_b,
    input  logic               i_a_valid,
    input  logic               i_b_valid,
    output logic               o_strobe,
    output wpc_pkg::t_operand  o_result_value,
    output logic               o_write_enable
);
    import wpc_pkg::*;

    localparam int N = CORDIC_STAGES;
    // Edges from acceptance to the edge that takes the result.
    localparam int LAT = N + 7;

    localparam logic signed [DW:0]     ROT_ROUND = (DW+1)'(64'd1 << 23);
    localparam logic signed [DW-24:0]  RQ_MAX    = (DW-23)'(RES_MAX);
    localparam logic signed [DW-24:0]  RQ_MIN    = (DW-23)'(RES_MIN);
    localparam logic signed [49:0]     DIR_ROUND = 50'(64'd1 << 31);
    localparam logic [63:0]            SPD_ROUND = 64'd1 << 37;
    localparam logic [25:0]            SPD_MAX   = 26'(RES_MAX);

    // The block never holds off an item.
    assign busy = 1'b0;

    // Mode register. It is captured with every item so that each item carries
    // its own mode through the pipeline.
    t_mode r_cfg_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= MODE_EAST;
        end else if (i_cfg_we) begin
            r_cfg_mode <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Front end, stages 1 to 4: degrees to binary angle.
    // The angle is floor((d * 2^21 + 22) / 45) modulo 2^32, which equals the
    // angle of d reduced into one turn. Splitting d = 45*q + r gives the angle
    // as q * 2^21 plus a table entry for r. The quotient comes from a
    // reciprocal multiply on the offset, non-negative operand. The speed is
    // multiplied by the inverse CORDIC gain in parallel.
    // ------------------------------------------------------------------
    logic                   r1_vld, r2_vld, r3_vld, r4_vld;
    t_mode                  r1_mode, r2_mode, r3_mode, r4_mode;
    logic                   r1_ok, r2_ok, r3_ok, r4_ok;
    t_operand               r1_a, r2_a, r3_a, r4_a;
    t_operand               r1_b, r2_b, r3_b, r4_b;
    logic [DIVIDEND_W-1:0]  r1_du, r2_du;
    logic [QUOT_W-1:0]      r2_dq, r3_dq;
    logic [5:0]             r3_dr;
    logic signed [56:0]     r2_kprod, r3_kprod, r4_kprod;
    logic [31:0]            r4_z;

    logic [DIVIDEND_W-1:0]          n1_du;
    logic [DIVIDEND_W+RECIP_W-1:0]  n2_qprod;
    logic signed [56:0]             n2_kprod;
    logic [DIVIDEND_W-1:0]          n3_rem;
    logic [31:0]                    n4_z;

    assign n1_du    = DIVIDEND_W'(i_operand_b) + DEG_OFFSET;
    assign n2_qprod = {{RECIP_W{1'b0}}, r1_du} * {{DIVIDEND_W{1'b0}}, RECIP45};
    assign n2_kprod = 57'(r1_a) * 57'(KINV);
    assign n3_rem   = r2_du - DIVIDEND_W'({{(DIVIDEND_W-QUOT_W){1'b0}}, r2_dq}
                                          * DIVIDEND_W'(DEG_DIV));
    assign n4_z     = {r3_dq[10:0], 21'd0} - Z_OFFSET + {11'd0, DR_TAB[r3_dr]};

    always_ff @(posedge i_clk) begin
        r1_mode  <= r_cfg_mode;
        r1_ok    <= i_a_valid & i_b_valid;
        r1_a     <= i_operand_a;
        r1_b     <= i_operand_b;
        r1_du    <= n1_du;

        r2_mode  <= r1_mode;
        r2_ok    <= r1_ok;
        r2_a     <= r1_a;
        r2_b     <= r1_b;
        r2_du    <= r1_du;
        r2_dq    <= n2_qprod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        r2_kprod <= n2_kprod;

        r3_mode  <= r2_mode;
        r3_ok    <= r2_ok;
        r3_a     <= r2_a;
        r3_b     <= r2_b;
        r3_dq    <= r2_dq;
        r3_dr    <= n3_rem[5:0];
        r3_kprod <= r2_kprod;

        r4_mode  <= r3_mode;
        r4_ok    <= r3_ok;
        r4_a     <= r3_a;
        r4_b     <= r3_b;
        r4_z     <= n4_z;
        r4_kprod <= r3_kprod;
    end

    // ------------------------------------------------------------------
    // CORDIC start vector (stage 5, index 0 of the stage arrays).
    // Rotation folds angles beyond a quarter turn by negating the vector.
    // Vectoring starts from (-y, -x); a vector in the left half plane is
    // negated and starts at half a turn.
    // ------------------------------------------------------------------
    logic [N:0]             r_cvld;
    t_mode                  r_cmode [N+1];
    logic                   r_cok   [N+1];
    logic                   r_czero [N+1];
    logic signed [DW-1:0]   r_cx    [N+1];
    logic signed [DW-1:0]   r_cy    [N+1];
    logic signed [ZW-1:0]   r_cz    [N+1];

    logic                   n5_vector;
    logic signed [DW-1:0]   n5_x0, n5_ax, n5_bx;
    logic signed [ZW-1:0]   n5_zs;
    logic signed [DW-1:0]   n5_x, n5_y;
    logic signed [ZW-1:0]   n5_z;

    assign n5_vector = (r4_mode == MODE_SPEED) || (r4_mode == MODE_DIR);
    assign n5_x0     = DW'(r4_kprod >>> 8);
    assign n5_ax     = $signed({{(DW-2*OPW){r4_a[OPW-1]}}, r4_a, 24'd0});
    assign n5_bx     = $signed({{(DW-2*OPW){r4_b[OPW-1]}}, r4_b, 24'd0});
    assign n5_zs     = ZW'($signed(r4_z));

    always_comb begin
        n5_x = n5_x0;
        n5_y = '0;
        n5_z = n5_zs;
        if (n5_vector) begin
            if (r4_b > 0) begin
                n5_x = n5_bx;
                n5_y = n5_ax;
                n5_z = Z_HALF;
            end else begin
                n5_x = -n5_bx;
                n5_y = -n5_ax;
                n5_z = '0;
            end
        end else if (n5_zs > Z_QUARTER) begin
            n5_x = -n5_x0;
            n5_z = n5_zs - Z_HALF;
        end else if (n5_zs < -Z_QUARTER) begin
            n5_x = -n5_x0;
            n5_z = n5_zs + Z_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmode[0] <= r4_mode;
        r_cok[0]   <= r4_ok;
        r_czero[0] <= (r4_a == '0) && (r4_b == '0);
        r_cx[0]    <= n5_x;
        r_cy[0]    <= n5_y;
        r_cz[0]    <= n5_z;
    end

    // ------------------------------------------------------------------
    // CORDIC micro-rotations, one register stage each. Rotation turns
    // counterclockwise while the residual angle is non-negative; vectoring
    // turns counterclockwise while y is negative, driving y toward zero.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [ZW-1:0] STEP_ANGLE = atan_angle(i);

        logic                 rot;
        logic                 ccw;
        logic signed [DW-1:0] sx, sy;

        assign rot = (r_cmode[i] == MODE_EAST) || (r_cmode[i] == MODE_NORTH);
        assign ccw = rot ? !r_cz[i][ZW-1] : r_cy[i][DW-1];
        assign sx  = r_cy[i] >>> i;
        assign sy  = r_cx[i] >>> i;

        always_ff @(posedge i_clk) begin
            r_cmode[i+1] <= r_cmode[i];
            r_cok[i+1]   <= r_cok[i];
            r_czero[i+1] <= r_czero[i];
            if (ccw) begin
                r_cx[i+1] <= r_cx[i] - sx;
                r_cy[i+1] <= r_cy[i] + sy;
                r_cz[i+1] <= r_cz[i] - STEP_ANGLE;
            end else begin
                r_cx[i+1] <= r_cx[i] + sx;
                r_cy[i+1] <= r_cy[i] - sy;
                r_cz[i+1] <= r_cz[i] + STEP_ANGLE;
            end
        end
    end

    // ------------------------------------------------------------------
    // Back end, stage 6: rounding add for the components, degree scaling of
    // the wrapped angle, gain correction of the magnitude.
    // ------------------------------------------------------------------
    logic                   r6_vld;
    t_mode                  r6_mode;
    logic                   r6_ok, r6_zero;
    logic signed [DW:0]     r6_rot;
    logic signed [49:0]     r6_dir;
    logic [62:0]            r6_spd;

    logic signed [DW:0]     n6_rot;
    logic signed [49:0]     n6_dir;
    logic [62:0]            n6_spd;

    // East is -y and north is -x; 2^23 rounds before the shift by 24.
    assign n6_rot = ROT_ROUND - (DW+1)'((r_cmode[N] == MODE_NORTH) ? r_cx[N] : r_cy[N]);
    assign n6_dir = 50'($signed(r_cz[N][31:0])) * 50'(DEG_FULL);
    assign n6_spd = {32'd0, r_cx[N][SPD_LSB+SPD_W-1:SPD_LSB]} * {31'd0, KINV[31:0]};

    always_ff @(posedge i_clk) begin
        r6_mode <= r_cmode[N];
        r6_ok   <= r_cok[N];
        r6_zero <= r_czero[N];
        r6_rot  <= n6_rot;
        r6_dir  <= n6_dir;
        r6_spd  <= n6_spd;
    end

    // ------------------------------------------------------------------
    // Stage 7: shift, saturate and select into the output register.
    // ------------------------------------------------------------------
    logic signed [DW-24:0]  n7_rq;
    logic signed [49:0]     n7_dsum;
    logic [63:0]            n7_ssum;
    logic [25:0]            n7_s;
    t_operand               n7_value;

    assign n7_rq   = $signed(r6_rot[DW:24]);
    assign n7_dsum = r6_dir + DIR_ROUND;
    assign n7_ssum = {1'b0, r6_spd} + SPD_ROUND;
    assign n7_s    = n7_ssum[63:38];

    always_comb begin
        n7_value = '0;
        case (r6_mode) inside
            MODE_EAST, MODE_NORTH: begin
                if (n7_rq > RQ_MAX) begin
                    n7_value = RES_MAX;
                end else if (n7_rq < RQ_MIN) begin
                    n7_value = RES_MIN;
                end else begin
                    n7_value = n7_rq[OPW-1:0];
                end
            end
            MODE_SPEED: begin
                // A zero vector gives zero speed without correction.
                if (r6_zero) begin
                    n7_value = '0;
                end else if (n7_s > SPD_MAX) begin
                    n7_value = RES_MAX;
                end else begin
                    n7_value = $signed(n7_s[OPW-1:0]);
                end
            end
            default: begin
                // Calm wind reports a direction of -180 degrees.
                if (r6_zero) begin
                    n7_value = DIR_ZERO;
                end else begin
                    n7_value = $signed({{(OPW-18){n7_dsum[49]}}, n7_dsum[49:32]});
                end
            end
        endcase
        if (!r6_ok) begin
            n7_value = '0;
        end
    end

    logic      r_out_strobe;
    logic      r_out_we;
    t_operand  r_out_value;

    always_ff @(posedge i_clk) begin
        r_out_value <= n7_value;
    end

    // Valid bits of every stage; besides the mode register, only these, the output strobe and write enable are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld       <= 1'b0;
            r2_vld       <= 1'b0;
            r3_vld       <= 1'b0;
            r4_vld       <= 1'b0;
            r_cvld       <= '0;
            r6_vld       <= 1'b0;
            r_out_strobe <= 1'b0;
            r_out_we     <= 1'b0;
        end else begin
            r1_vld       <= start & !busy;
            r2_vld       <= r1_vld;
            r3_vld       <= r2_vld;
            r4_vld       <= r3_vld;
            r_cvld       <= {r_cvld[N-1:0], r4_vld};
            r6_vld       <= r_cvld[N];
            r_out_strobe <= r6_vld;
            r_out_we     <= r6_vld & r6_ok;
        end
    end

    assign o_strobe       = r_out_strobe;
    assign o_write_enable = r_out_we;
    assign o_result_value = r_out_value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_strobe_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result strobe without an accepted item");

    a_we_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_enable |-> o_strobe)
        else $error("write enable outside a result");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_write_enable) |-> (o_result_value == '0))
        else $error("invalid operand item gave a nonzero result");

    a_remainder_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld |-> (r3_dr < 6'(DEG_DIV)))
        else $error("degree remainder out of range");

    a_rot_start_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cvld[0] && (r_cmode[0] == MODE_EAST || r_cmode[0] == MODE_NORTH))
        |-> (r_cz[0] <= Z_QUARTER && r_cz[0] >= -Z_QUARTER))
        else $error("rotation start angle beyond a quarter turn");

    a_vec_x_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cvld[N] && (r_cmode[N] == MODE_SPEED || r_cmode[N] == MODE_DIR))
        |-> !r_cx[N][DW-1])
        else $error("vectoring magnitude negative");

endmodule

// File: tb/sv/wind_polar_cartesian_convert_tb.sv
module wind_polar_cartesian_convert_tb;
    import wpc_pkg::*;

    // A strobe follows its item by a fixed pipeline delay.
    localparam int PIPE_LATENCY    = CORDIC_STAGES + 6;
    // Cycles without any accepted item or result before the run is declared hung.
    // The longest legal quiet stretch is a sender gap plus a pipeline flush plus
    // the closing wait, all well under this.
    localparam int STALL_LIMIT     = 1000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 150;

    // Degrees per full turn in Q15.8, and binary angles (2^32 per turn).
    localparam longint TURN_Q8      = 92160;
    localparam longint QUARTER_TURN = 64'sd1 <<< 30;
    localparam longint HALF_TURN    = 64'sd1 <<< 31;
    // Inverse CORDIC gain, Q0.32.
    localparam longint GAIN_INV     = 64'sd2608131496;

    // Arctangent of 2^-i as a binary angle.
    localparam longint ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        t_operand value;
        logic     we;
    } t_wind_result;

    // One row of the directed table. When known is set, the expected result is
    // typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        t_mode        mode;
        t_operand     a;
        t_operand     b;
        logic         a_ok;
        logic         b_ok;
        logic         known;
        t_wind_result result;
    } t_point_row;

    localparam t_wind_result NO_RESULT = '{24'sd0, 1'b0};

    // Rows are grouped by mode so that the mode register only changes a few times.
    // The first group runs in the mode left by reset, without any register write.
    localparam t_point_row DIRECTED_POINTS [21] = '{
        // East component: wind from north, from east, extremes of speed and
        // direction, a negative speed and a missing speed.
        '{MODE_EAST,  24'sd256,    24'sd0,     1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_EAST,  RES_MAX,     24'sd23040, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_EAST,  RES_MIN,     RES_MIN,    1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_EAST,  RES_MAX,     RES_MAX,    1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_EAST,  -24'sd1280,  24'sd11520, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_EAST,  24'sd256,    24'sd0,     1'b0, 1'b1, 1'b1, NO_RESULT},
        // North component: a full turn of 360 degrees wraps back to zero.
        '{MODE_NORTH, 24'sd256,    24'sd0,     1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_NORTH, RES_MIN,     24'sd46080, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_NORTH, -24'sd256,   24'sd92160, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_NORTH, 24'sd1,      24'sd1,     1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_NORTH, 24'sd256,    24'sd0,     1'b1, 1'b0, 1'b1, NO_RESULT},
        // Speed: a zero vector gives zero and both corners saturate.
        '{MODE_SPEED, 24'sd0,      24'sd0,     1'b1, 1'b1, 1'b1, '{24'sd0, 1'b1}},
        '{MODE_SPEED, RES_MAX,     RES_MAX,    1'b1, 1'b1, 1'b1, '{RES_MAX, 1'b1}},
        '{MODE_SPEED, RES_MIN,     RES_MIN,    1'b1, 1'b1, 1'b1, '{RES_MAX, 1'b1}},
        '{MODE_SPEED, 24'sd768,    24'sd1024,  1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_SPEED, 24'sd768,    24'sd1024,  1'b0, 1'b0, 1'b1, NO_RESULT},
        // Direction: a zero vector reads as -180 degrees.
        '{MODE_DIR,   24'sd0,      24'sd0,     1'b1, 1'b1, 1'b1, '{DIR_ZERO, 1'b1}},
        '{MODE_DIR,   -24'sd256,   24'sd0,     1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_DIR,   24'sd0,      24'sd256,   1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_DIR,   RES_MAX,     RES_MIN,    1'b1, 1'b1, 1'b0, NO_RESULT},
        '{MODE_DIR,   24'sd512,    -24'sd512,  1'b0, 1'b1, 1'b1, NO_RESULT}
    };

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    logic         i_cfg_we;
    t_mode        i_cfg_wdata;
    t_operand     i_operand_a;
    t_operand     i_operand_b;
    logic         i_a_valid;
    logic         i_b_valid;
    logic         o_strobe;
    t_operand     o_result_value;
    logic         o_write_enable;

    // Copy of the mode register as the block should hold it.
    t_mode        mode_now;
    // Results still owed by the block, oldest first.
    t_wind_result owed_results [$];
    int           failures    = 0;
    int           idle_cycles = 0;

    wind_polar_cartesian_convert dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_a_valid      (i_a_valid),
        .i_b_valid      (i_b_valid),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_write_enable (o_write_enable)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor. All arithmetic is 64-bit two's complement; >>> is a floor
    // shift on signed operands, which is what the fixed-point definition uses.
    // ------------------------------------------------------------------

    // Keeps the low 32 bits of a binary angle as a signed value in [-2^31, 2^31).
    function automatic longint wrap_turn(longint z);
        return longint'($signed(z[31:0]));
    endfunction

    function automatic t_operand clamp_q8(longint v);
        if (v > 64'sd8388607) return RES_MAX;
        if (v < -64'sd8388608) return RES_MIN;
        return t_operand'(v);
    endfunction

    // East or north component from speed and "blowing from" direction.
    function automatic t_operand rotate_wind(longint speed, longint deg, bit north);
        longint r, x, y, z, dx, dy;
        r = deg % TURN_Q8;
        if (r < 0) r += TURN_Q8;
        z = wrap_turn(((r <<< 32) + TURN_Q8 / 2) / TURN_Q8);
        x = (speed * GAIN_INV) >>> 8;
        y = 0;
        // Fold the back half-plane onto the front one, where CORDIC converges.
        if (z > QUARTER_TURN) begin
            z -= HALF_TURN;
            x = -x;
        end else if (z < -QUARTER_TURN) begin
            z += HALF_TURN;
            x = -x;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ATAN_TURN[i];
            end else begin
                x += dx;
                y -= dy;
                z += ATAN_TURN[i];
            end
        end
        return clamp_q8(((north ? -x : -y) + (64'sd1 <<< 23)) >>> 24);
    endfunction

    // Speed or direction from the east (xin) and north (yin) components.
    function automatic t_operand vector_wind(longint xin, longint yin, bit dir);
        longint      x, y, z, dx, dy;
        logic [63:0] mag;
        x = -(yin * 64'sd16777216);
        y = -(xin * 64'sd16777216);
        z = 0;
        if (xin == 0 && yin == 0) return dir ? DIR_ZERO : 24'sd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += ATAN_TURN[i];
            end else begin
                x -= dx;
                y += dy;
                z -= ATAN_TURN[i];
            end
        end
        if (dir) return t_operand'((wrap_turn(z) * TURN_Q8 + HALF_TURN) >>> 32);
        mag = 64'(x) >> 18;
        mag = (mag * 64'd2608131496 + (64'd1 << 37)) >> 38;
        return (mag > 64'd8388607) ? RES_MAX : t_operand'(mag);
    endfunction

    function automatic t_wind_result predict_point(t_mode m, t_operand a, t_operand b,
                                                   logic a_ok, logic b_ok);
        t_wind_result r;
        r.value = 24'sd0;
        r.we    = a_ok && b_ok;
        if (r.we) begin
            case (m)
                MODE_EAST:  r.value = rotate_wind(a, b, 1'b0);
                MODE_NORTH: r.value = rotate_wind(a, b, 1'b1);
                MODE_SPEED: r.value = vector_wind(a, b, 1'b0);
                default:    r.value = vector_wind(a, b, 1'b1);
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers. Inputs change at the falling edge only.
    // ------------------------------------------------------------------

    // Random operand: mostly ordinary values, with full-range values to toggle
    // every bit, the extremes, and values near zero mixed in. An angle operand
    // usually stays within one turn but sometimes goes outside it.
    function automatic t_operand random_operand(bit angle);
        case ($urandom_range(0, 9))
            0, 1: return t_operand'($urandom);
            2: begin
                case ($urandom_range(0, 4))
                    0:       return RES_MAX;
                    1:       return RES_MIN;
                    2:       return 24'sd0;
                    3:       return 24'sd1;
                    default: return -24'sd1;
                endcase
            end
            3, 4: return t_operand'(int'($urandom_range(0, 4095)) - 2048);
            default: begin
                if (angle) return t_operand'($urandom_range(0, 92159));
                return t_operand'(int'($urandom_range(0, 2097151)) - 1048576);
            end
        endcase
    endfunction

    // Presents one item, holds it until the block takes it, and records what the
    // block owes for it. Start is left high so the next item can follow at once.
    task automatic send_point(input t_operand a, input t_operand b, input logic a_ok,
                              input logic b_ok, input bit known, input t_wind_result given);
        @(negedge i_clk);
        start       = 1'b1;
        i_operand_a = a;
        i_operand_b = b;
        i_a_valid   = a_ok;
        i_b_valid   = b_ok;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        owed_results.push_back(known ? given : predict_point(mode_now, a, b, a_ok, b_ok));
    endtask

    // Drops start for the given number of cycles, with noise on the operand ports.
    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start       = 1'b0;
            i_operand_a = t_operand'($urandom);
            i_operand_b = t_operand'($urandom);
            i_a_valid   = 1'($urandom);
            i_b_valid   = 1'($urandom);
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Every item yields a strobe, so an empty list of owed results means the
    // pipeline is empty; a few extra cycles are spent anyway for margin.
    task automatic drain_pipeline();
        idle_gap(1);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        drain_pipeline();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = m;
        @(posedge i_clk);
        mode_now = m;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checking and the stall counter, both on the rising edge, where the
    // block's outputs still hold the values of the cycle that is ending.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_wind_result want;
        if (!i_rst_n || (start && !busy) || o_strobe) idle_cycles = 0;
        else idle_cycles++;
        if (i_rst_n && o_strobe) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result: result_value %0d write_enable %0b",
                       o_result_value, o_write_enable);
                failures++;
            end else begin
                want = owed_results.pop_front();
                if (o_result_value !== want.value) begin
                    $error("result_value: expected %0d, got %0d", want.value, o_result_value);
                    failures++;
                end
                if (o_write_enable !== want.we) begin
                    $error("write_enable: expected %0b, got %0b", want.we, o_write_enable);
                    failures++;
                end
            end
        end
    end

    // Ends a hung run: nothing accepted on either side for too long.
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("[wind_polar_cartesian_convert] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random phases, each with a mode
    // written at its start, with the sender working in bursts, most of them after a gap.
    // ------------------------------------------------------------------
    initial begin
        t_point_row row;
        int         burst_left;
        bit         rotating;
        logic       a_ok, b_ok;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = MODE_EAST;
        i_operand_a = 24'sd0;
        i_operand_b = 24'sd0;
        i_a_valid   = 1'b0;
        i_b_valid   = 1'b0;
        mode_now    = MODE_EAST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. The first group relies on the mode left by reset.
        for (int i = 0; i < $size(DIRECTED_POINTS); i++) begin
            row = DIRECTED_POINTS[i];
            if (row.mode != mode_now) write_mode(row.mode);
            send_point(row.a, row.b, row.a_ok, row.b_ok, row.known, row.result);
            idle_gap($urandom_range(0, 2));
        end

        // Random part. The first two phases pin the mode to its two extremes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) write_mode(MODE_DIR);
            else if (phase == 1) write_mode(MODE_EAST);
            else write_mode(t_mode'($urandom_range(0, 3)));
            rotating   = (mode_now == MODE_EAST) || (mode_now == MODE_NORTH);
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    // Now and then a long burst runs straight on with no gap at all.
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(40, 80);
                    end else begin
                        idle_gap($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6));
                        burst_left = $urandom_range(1, 16);
                    end
                end
                // Most points carry both operands; a missing one blocks the write.
                a_ok = ($urandom_range(0, 15) != 0);
                b_ok = ($urandom_range(0, 15) != 0);
                send_point(random_operand(1'b0), random_operand(rotating), a_ok, b_ok,
                           1'b0, NO_RESULT);
                burst_left--;
            end
        end

        // Let every owed result arrive, then watch a while longer for strays.
        drain_pipeline();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (failures == 0 && owed_results.size() == 0) begin
            $display("[wind_polar_cartesian_convert] OK");
        end else begin
            $display("[wind_polar_cartesian_convert] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
src/wpc_pkg.sv
src/wind_polar_cartesian_convert.sv
tb/sv/wind_polar_cartesian_convert_tb.sv
